// ===== hdl/assert_macros.svh =====
// assertion macros for the top-level rtl file of the 48-bit lcg block
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hdl/lcg48_pkg.sv =====
// types, constants and command codes of the 48-bit lcg block
// no dependencies; imported by controller, datapath and top level
`default_nettype none

package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int HALF_W  = 24;
    localparam int DRAW_W  = 31;
    localparam int WORD_W  = 32;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 5;

    // lcg multiplier and increment, multiplier split into 24-bit halves
    localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD  = 48'd11;
    localparam logic [HALF_W-1:0]  MULT_LO  = 24'hECE66D;
    localparam logic [HALF_W-1:0]  MULT_HI  = 24'h0005DE;
    localparam logic [CNT_W-1:0]   DIV_LAST_BIT = 5'd30;

    // request modes
    typedef enum logic [1:0] {
        MODE_RESEED  = 2'd0,
        MODE_BOUNDED = 2'd1,
        MODE_WIDE    = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_e_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [63:0] seed_value;
        logic signed [31:0] bound;
    } req_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               bad_bound;
    } rsp_t;

    // partial product selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LL   = 2'd1,
        MUL_LH   = 2'd2,
        MUL_HL   = 2'd3
    } mul_op_t;

    // result source selection
    typedef enum logic [2:0] {
        RES_ZERO  = 3'd0,
        RES_BAD   = 3'd1,
        RES_REM   = 3'd2,
        RES_SCALE = 3'd3,
        RES_WIDE  = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     reseed;
        mul_op_t  mul_op;
        logic     div_step;
        logic     save_hi;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       bound_bad;
        logic       pow2;
        logic       div_last;
        logic       reject;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/lcg48_ctrl.sv =====
// controller state machine of the 48-bit lcg block
// depends on lcg48_pkg; drives datapath commands from its status
`default_nettype none

module lcg48_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire lcg48_pkg::status_t status,
    output lcg48_pkg::cmd_t         cmd
);
    import lcg48_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DISP  = 9'b000000010,
        ST_MUL0  = 9'b000000100,
        ST_MUL1  = 9'b000001000,
        ST_MUL2  = 9'b000010000,
        ST_POST  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_CHECK = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    // one request at a time
    assign req_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                second_next = 1'b0;
                priority if (status.mode == MODE_RESEED)
                begin
                    cmd.reseed   = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                    state_next   = ST_DONE;
                end
                else if (status.mode == MODE_BOUNDED && status.bound_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_BAD;
                    state_next   = ST_DONE;
                end
                else if (status.mode == MODE_BOUNDED || status.mode == MODE_WIDE)
                begin
                    state_next = ST_MUL0;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_ZERO;
                    state_next   = ST_DONE;
                end
            end
            ST_MUL0:
            begin
                cmd.mul_op = MUL_LL;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_op = MUL_LH;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_op = MUL_HL;
                state_next = ST_POST;
            end
            ST_POST:
            begin
                priority if (status.mode == MODE_WIDE)
                begin
                    if (!second_reg)
                    begin
                        cmd.save_hi = 1'b1;
                        second_next = 1'b1;
                        state_next  = ST_MUL0;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_WIDE;
                        state_next   = ST_DONE;
                    end
                end
                else if (status.pow2)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_SCALE;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.reject)
                begin
                    state_next = ST_MUL0;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_REM;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcg48_dp.sv =====
// datapath of the 48-bit lcg block: generator state, shared 24x24 multiplier,
// bit-serial remainder unit, result and output registers; depends on lcg48_pkg
`default_nettype none

module lcg48_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lcg48_pkg::req_t  req_data,
    input  wire lcg48_pkg::cmd_t  cmd,
    output lcg48_pkg::status_t    status,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output lcg48_pkg::rsp_t       rsp_data
);
    import lcg48_pkg::*;

    req_t                 req_reg;
    logic [STATE_W-1:0]   state_reg, state_next;
    logic [STATE_W-1:0]   acc_reg, acc_next;
    logic [HALF_W-1:0]    mul_a, mul_b;
    logic [STATE_W-1:0]   prod;
    logic [STATE_W-1:0]   prod_shift;
    logic [WORD_W-1:0]    bound_u;
    logic [DRAW_W-1:0]    draw;
    logic [DRAW_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0]    trial;
    logic [WORD_W-1:0]    accept_sum;
    logic [VALUE_W-1:0]   scale_prod;
    logic [WORD_W-1:0]    hi_reg;
    logic [WORD_W-1:0]    lo_word;
    rsp_t                 res_reg, res_next;
    rsp_t                 out_reg;
    logic                 out_valid_reg;

    assign bound_u = req_reg.bound;
    assign draw    = state_reg[STATE_W-1:STATE_W-DRAW_W];
    assign lo_word = state_reg[STATE_W-1:STATE_W-WORD_W];

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_LL:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = MULT_LO;
            end
            MUL_LH:
            begin
                mul_a = state_reg[HALF_W-1:0];
                mul_b = MULT_HI;
            end
            MUL_HL:
            begin
                mul_a = state_reg[STATE_W-1:HALF_W];
                mul_b = MULT_LO;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod       = mul_a * mul_b;
    assign prod_shift = {prod[HALF_W-1:0], {HALF_W{1'b0}}};

    // lcg step accumulated over the LL, LH and HL partial products, reseed on request
    always_comb
    begin
        acc_next   = acc_reg;
        state_next = state_reg;
        unique case (cmd.mul_op)
            MUL_LL:   acc_next = prod + LCG_ADD;
            MUL_LH:   acc_next = acc_reg + prod_shift;
            MUL_HL:   state_next = acc_reg + prod_shift;
            default:  acc_next = acc_reg;
        endcase
        if (cmd.reseed)
        begin
            state_next = req_reg.seed_value[STATE_W-1:0] ^ LCG_MULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // restoring remainder, one draw bit per cycle from the msb down
    assign trial = {rem_reg, draw[cnt_reg]};

    always_comb
    begin
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.mul_op == MUL_HL)
        begin
            rem_next = '0;
            cnt_next = DIV_LAST_BIT;
        end
        else if (cmd.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= bound_u)
            begin
                rem_next = DRAW_W'(trial - bound_u);
            end
            else
            begin
                rem_next = trial[DRAW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // rejection test in 32-bit wrapping arithmetic
    assign accept_sum = {1'b0, draw} - {1'b0, rem_reg} + (bound_u - 1'b1);

    // power-of-two bound scaling
    assign scale_prod = bound_u * {1'b0, draw};

    // upper word of the wide draw
    always_ff @(posedge clk)
    begin
        if (cmd.save_hi)
        begin
            hi_reg <= lo_word;
        end
    end

    // result selection
    always_comb
    begin
        res_next = '0;
        unique case (cmd.res_sel)
            RES_ZERO:  res_next = '0;
            RES_BAD:   res_next.bad_bound = 1'b1;
            RES_REM:   res_next.value = {{(VALUE_W-DRAW_W){1'b0}}, rem_reg};
            RES_SCALE: res_next.value = {{(VALUE_W-WORD_W){1'b0}},
                                         scale_prod[DRAW_W+WORD_W-1:DRAW_W]};
            RES_WIDE:  res_next.value = {hi_reg - {{(WORD_W-1){1'b0}}, lo_word[WORD_W-1]},
                                         lo_word};
            default:   res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // status to controller
    assign status.mode      = req_reg.mode;
    assign status.bound_bad = bound_u[WORD_W-1] | (bound_u == '0);
    assign status.pow2      = ((bound_u & (bound_u - 1'b1)) == '0);
    assign status.div_last  = (cnt_reg == '0);
    assign status.reject    = accept_sum[WORD_W-1];
    assign status.out_free  = !out_valid_reg || !rsp_stall;

endmodule

`default_nettype wire

// ===== hdl/lcg48_random_generator.sv =====
// path of a request: reseed, error and spare modes go from dispatch straight to done;
// a power-of-two bound takes one lcg step, a 64-bit draw two, other bounds one lcg step
// and the remainder unit, repeated on each retry; one request in flight, the next beat
// is taken in the cycle after the result enters the output register, which waits on rsp_stall
// each lcg step runs the LL, LH and HL products on the shared 24x24 multiplier, then the post state;
// the remainder unit resolves one bit per cycle; reset: generator state
// cleared to zero, controller idle, output register empty
`default_nettype none

module lcg48_random_generator (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire lcg48_pkg::req_t  req_data,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output lcg48_pkg::rsp_t       rsp_data
);
    import lcg48_pkg::*;

    cmd_t    cmd;
    status_t status;

    // controller
    lcg48_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    lcg48_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // checks
`include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall)
    `ASSERT_IMPLY(a_load_only_when_free, clk, rst_n, cmd.out_load, !rsp_valid || !rsp_stall)
    `ASSERT_IMPLY(a_bad_gives_zero, clk, rst_n, rsp_valid && rsp_data.bad_bound, rsp_data.value == '0)
    `ASSERT_ALWAYS(a_no_load_while_busy, clk, rst_n, !(cmd.load && cmd.res_load))

endmodule

`default_nettype wire

// ===== sim/lcg48_random_generator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the 48-bit lcg random generator
// depends on lcg48_pkg and lcg48_random_generator; drives valid/stall beats on both channels

module lcg48_random_generator_tb;

    import lcg48_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          RANDOM_BLOCKS = 11;
    localparam int          BLOCK_ITEMS   = 100;
    localparam int          SETTLE_CYCLES = 60;

    // tracks the generator state and the results it must produce
    class lcg_draw_board;
        logic [47:0] lcg_state;
        rsp_t        expected_draws[$];
        int          errors;
        int          n_checked;
        int          n_reseed;
        int          n_bounded;
        int          n_bad;
        int          n_wide;
        int          n_retries;

        function new();
            lcg_state = '0;
            errors    = 0;
            n_checked = 0;
            n_reseed  = 0;
            n_bounded = 0;
            n_bad     = 0;
            n_wide    = 0;
            n_retries = 0;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        // one lcg step, wrapping in 48 bits
        function logic [47:0] advance();
            lcg_state = lcg_state * LCG_MULT + LCG_ADD;
            return lcg_state;
        endfunction

        function logic [31:0] draw31();
            logic [47:0] s;
            s = advance();
            return {1'b0, s[47:17]};
        endfunction

        function logic [63:0] draw32_sext();
            logic [47:0] s;
            s = advance();
            return {{32{s[47]}}, s[47:16]};
        endfunction

        // predict the result of one accepted request beat
        function void note_request(req_t r);
            rsp_t        e;
            logic [31:0] n;
            logic [31:0] r31;
            logic [31:0] rem;
            logic [31:0] chk;
            logic [63:0] prod;
            logic [63:0] hi;
            logic [63:0] lo;
            int          tries;
            e     = '0;
            tries = 0;
            case (mode_e_t'(r.mode))
                MODE_RESEED:
                begin
                    lcg_state = r.seed_value[47:0] ^ LCG_MULT;
                    n_reseed++;
                end
                MODE_BOUNDED:
                begin
                    n = r.bound;
                    n_bounded++;
                    if (n == 32'd0 || n[31])
                    begin
                        e.bad_bound = 1'b1;
                        n_bad++;
                    end
                    else if ((n & (n - 32'd1)) == 32'd0)
                    begin
                        // power-of-two bound: scale the draw, no rejection
                        r31     = draw31();
                        prod    = {32'd0, n} * {32'd0, r31};
                        e.value = prod >> 31;
                    end
                    else
                    begin
                        // reject draws from the last partial block of the range
                        do
                        begin
                            r31 = draw31();
                            rem = r31 % n;
                            chk = r31 - rem + n - 32'd1;
                            tries++;
                        end while (chk[31]);
                        n_retries += tries - 1;
                        e.value = {32'd0, rem};
                    end
                end
                MODE_WIDE:
                begin
                    hi      = draw32_sext();
                    lo      = draw32_sext();
                    e.value = (hi << 32) + lo;
                    n_wide++;
                end
                default:
                begin
                end
            endcase
            expected_draws.push_back(e);
        endfunction

        // compare one accepted result beat with the oldest prediction
        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_draws.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, value %h bad_bound %b",
                         $time, got.value, got.bad_bound);
                return;
            end
            e = expected_draws.pop_front();
            n_checked++;
            if (got.value !== e.value)
            begin
                errors++;
                $display("%0t: value mismatch, expected %h actual %h",
                         $time, e.value, got.value);
            end
            if (got.bad_bound !== e.bad_bound)
            begin
                errors++;
                $display("%0t: bad_bound mismatch, expected %b actual %b",
                         $time, e.bad_bound, got.bad_bound);
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_data;

    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;
    int unsigned cycle_count = 0;

    lcg_draw_board board = new();

    lcg48_random_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("FAIL lcg48_random_generator");
            $finish;
        end
    end

    function automatic int pause_len(bit steady);
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic req_t mk(mode_e_t m, logic [63:0] s, logic [31:0] b);
        req_t r;
        r.mode       = m;
        r.seed_value = s;
        r.bound      = b;
        return r;
    endfunction

    // mostly bounded draws across the bound classes, some wide draws and reseeds
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r = mk(MODE_BOUNDED, {$urandom, $urandom}, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            r.mode = MODE_RESEED;
        else if (pick < 35)
            r.mode = MODE_WIDE;
        else if (pick < 38)
            r.mode = MODE_SPARE;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r.bound = $urandom_range(1, 1000);
            else if (pick < 50)
                r.bound = 32'd1 << $urandom_range(0, 30);
            else if (pick < 65)
                r.bound = $urandom_range(32'h4000_0001, 32'h7fff_ffff);
            else if (pick < 80)
                r.bound = $urandom_range(1, 32'h7fff_ffff);
        end
        return r;
    endfunction

    // present one request beat after a gap and wait for it to be taken
    task automatic send_req(input req_t r, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        board.note_request(r);
    endtask

    // hold off the sender until every predicted result has come back
    task automatic wait_for_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    // result side: random stall before each beat, check on accept
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                hold--;
            end
            else
                rsp_stall <= 1'b0;
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                board.check_result(rsp_data);
                hold = pause_len(recv_steady);
            end
        end
    end

    // stimulus
    initial
    begin
        req_t directed[$];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // draws straight from the reset state, then bound extremes and error cases
        directed.push_back(mk(MODE_WIDE, {$urandom, $urandom}, $urandom));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'h4000_0000));
        directed.push_back(mk(MODE_RESEED, 64'd0, $urandom));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'd1));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'd2));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'd3));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'h7fff_ffff));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'h4000_0001));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'h4000_0001));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'd0));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'hffff_ffff));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'h8000_0000));
        directed.push_back(mk(MODE_WIDE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff));
        directed.push_back(mk(MODE_RESEED, 64'h7fff_ffff_ffff_ffff, 32'd0));
        directed.push_back(mk(MODE_BOUNDED, 64'd0, 32'd5));
        directed.push_back(mk(MODE_RESEED, 64'h8000_0000_0000_0000, 32'd0));
        directed.push_back(mk(MODE_WIDE, 64'd0, 32'd0));
        directed.push_back(mk(MODE_RESEED, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff));
        directed.push_back(mk(MODE_BOUNDED, 64'd0, 32'd1000));
        // seed that scrambles to an all-zero state
        directed.push_back(mk(MODE_RESEED, {16'hbeef, LCG_MULT}, 32'd0));
        directed.push_back(mk(MODE_WIDE, 64'd0, 32'd0));
        directed.push_back(mk(MODE_SPARE, {$urandom, $urandom}, $urandom));
        directed.push_back(mk(MODE_SPARE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff));
        directed.push_back(mk(MODE_BOUNDED, {$urandom, $urandom}, 32'd7));
        directed.push_back(mk(MODE_RESEED, {$urandom, $urandom}, $urandom));

        foreach (directed[i])
            send_req(directed[i], pause_len(send_steady));
        wait_for_drain();

        // random blocks, each with its own idling pattern, drained between blocks
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            send_steady = ($urandom_range(0, 2) == 0);
            recv_steady = ($urandom_range(0, 2) == 0);
            repeat (BLOCK_ITEMS)
                send_req(random_request(), pause_len(send_steady));
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bounded draws (%0d bad bounds, %0d rejected draws), %0d wide draws",
                 board.n_bounded, board.n_bad, board.n_retries, board.n_wide);
        $display("plus %0d reseeds; %0d result beats checked, %0d errors",
                 board.n_reseed, board.n_checked, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS lcg48_random_generator");
        else
            $display("FAIL lcg48_random_generator");
        $finish;
    end

endmodule
